### rtl/core/mss_pkg.sv
// ----------------------------------------------------------------------------
// Moisture sample sequencer package
// Widths, register codes, microcode types and the control store of the
// moisture sample sequencer.
// ----------------------------------------------------------------------------
package mss_pkg;

    localparam int PAIRS      = 3;
    localparam int SLOTS      = 2 * PAIRS + 1;
    localparam int SLOT_W     = $clog2(SLOTS);

    localparam int SAMPLE_W   = 10;
    localparam int MUX_W      = 6;
    localparam int RAW_W      = 11;
    localparam int PERMILLE_W = 10;

    localparam int FULL_SCALE = 1023;
    localparam int PERMILLE   = 1000;
    localparam int RAW_MAX    = (1 << RAW_W) - 1;

    localparam int MAG_W      = $clog2(PAIRS * FULL_SCALE + 1);
    localparam int ACC_W      = MAG_W + 1;
    localparam int MOIST_W    = MAG_W + 2;
    localparam int PROD_W     = $clog2(RAW_MAX * PERMILLE + 1);
    localparam int DVD_W      = (PROD_W > MAG_W) ? PROD_W : MAG_W;
    localparam int DVS_W      = RAW_W;
    localparam int DCNT_W     = $clog2(DVD_W);

    // The rounded-up reciprocal of PAIRS gives the exact quotient for every
    // dividend below 2^MAG_W, since PAIRS never exceeds eight.
    localparam int RECIP_SHIFT = MAG_W + 3;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int RECIP       = ((1 << RECIP_SHIFT) + PAIRS - 1) / PAIRS;
    localparam int AVGP_W      = MAG_W + RECIP_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [MUX_W-1:0] MUX_LOW_RESET   = MUX_W'(7);
    localparam logic [MUX_W-1:0] MUX_HIGH_RESET  = MUX_W'(5);
    localparam logic [MUX_W-1:0] MUX_THERM_RESET = MUX_W'(3);
    localparam logic [RAW_W-1:0] FLOOR_RESET     = RAW_W'(325);
    localparam logic [RAW_W-1:0] CEILING_RESET   = RAW_W'(615);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MUX_LOW   = 3'd0,
        CFG_MUX_HIGH  = 3'd1,
        CFG_MUX_THERM = 3'd2,
        CFG_FLOOR     = 3'd3,
        CFG_CEILING   = 3'd4
    } t_cfg_index;

    typedef enum logic [2:0] {
        UOP_CLEAR,
        UOP_ACCUM,
        UOP_LOAD_AVG,
        UOP_DIV_STEP,
        UOP_MOIST,
        UOP_RANGE,
        UOP_PERMILLE,
        UOP_FINISH
    } t_uop;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_IDX_MORE,
        COND_DIV_MORE,
        COND_SATURATED,
        COND_OUT_BUSY
    } t_cond;

    localparam int UPC_W = 4;

    localparam logic [UPC_W-1:0] UPC_CLEAR     = UPC_W'(0);
    localparam logic [UPC_W-1:0] UPC_ACCUM     = UPC_W'(1);
    localparam logic [UPC_W-1:0] UPC_LOAD_AVG  = UPC_W'(2);
    localparam logic [UPC_W-1:0] UPC_MOIST     = UPC_W'(3);
    localparam logic [UPC_W-1:0] UPC_RANGE     = UPC_W'(4);
    localparam logic [UPC_W-1:0] UPC_DIV_SCALE = UPC_W'(5);
    localparam logic [UPC_W-1:0] UPC_PERMILLE  = UPC_W'(6);
    localparam logic [UPC_W-1:0] UPC_FINISH    = UPC_W'(7);

    typedef struct packed {
        t_uop             op;
        t_cond            cond;
        logic [UPC_W-1:0] target;
    } t_uword;

    function automatic t_uword uc_rom(input logic [UPC_W-1:0] upc);
        t_uword w;
        unique case (upc)
            UPC_CLEAR:     w = '{op: UOP_CLEAR,    cond: COND_NEVER,     target: UPC_CLEAR};
            UPC_ACCUM:     w = '{op: UOP_ACCUM,    cond: COND_IDX_MORE,  target: UPC_ACCUM};
            UPC_LOAD_AVG:  w = '{op: UOP_LOAD_AVG, cond: COND_NEVER,     target: UPC_CLEAR};
            UPC_MOIST:     w = '{op: UOP_MOIST,    cond: COND_NEVER,     target: UPC_CLEAR};
            UPC_RANGE:     w = '{op: UOP_RANGE,    cond: COND_SATURATED, target: UPC_FINISH};
            UPC_DIV_SCALE: w = '{op: UOP_DIV_STEP, cond: COND_DIV_MORE,  target: UPC_DIV_SCALE};
            UPC_PERMILLE:  w = '{op: UOP_PERMILLE, cond: COND_NEVER,     target: UPC_CLEAR};
            default:       w = '{op: UOP_FINISH,   cond: COND_OUT_BUSY,  target: UPC_FINISH};
        endcase
        return w;
    endfunction

endpackage

### rtl/core/moisture_sample_sequencer.sv
// ----------------------------------------------------------------------------
// Moisture sample sequencer
// Files converter samples into a ring of slots, names the next mux channel
// and, once per measurement cycle, computes raw and per-mille moisture.
// ----------------------------------------------------------------------------
// Each input transfer carries one finished conversion for the current slot.
// Every input transfer produces exactly one output transfer, which names the
// next mux channel, the settle flag and the latest moisture results.
// A transfer that does not fill the last slot gives its registered result
// in the next cycle; such samples can be taken every cycle unless stalled.
// A transfer that fills the last slot starts the microcoded sequencer: it
// sums the samples, takes the average by a reciprocal multiplication in one
// step, computes raw moisture and checks its range, runs the per-mille
// shift-subtract division over the DVD_W (21) dividend bits and then gives
// the result; a saturated value skips the division.
// The input stalls while the sequencer runs and while a held result is not
// taken. The output register holds its result while the receiver stalls.
// Configuration writes are always ready and take effect at once.
// Reset clears the slot ring, the results and restores the register defaults.
// ----------------------------------------------------------------------------
module moisture_sample_sequencer import mss_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [SAMPLE_W-1:0]   i_sample,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [MUX_W-1:0]      o_next_mux,
    output logic                  o_start_delayed,
    output logic                  o_cycle_done,
    output logic [RAW_W-1:0]      o_moisture_raw,
    output logic [PERMILLE_W-1:0] o_moisture_permille,
    output logic [SAMPLE_W-1:0]   o_thermistor_raw,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state                    r_state;
    logic [UPC_W-1:0]          r_upc;
    logic [SAMPLE_W-1:0]       r_store [SLOTS];
    logic [SLOT_W-1:0]         r_slot;
    logic [SLOT_W-1:0]         r_idx;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_neg;
    logic [DVD_W-1:0]          r_quo;
    logic [DVS_W-1:0]          r_rem;
    logic [DVS_W-1:0]          r_dvs;
    logic [DCNT_W-1:0]         r_cnt;
    logic [RAW_W-1:0]          r_moist;
    logic [PERMILLE_W-1:0]     r_permille;
    logic [MUX_W-1:0]          r_mux_low;
    logic [MUX_W-1:0]          r_mux_high;
    logic [MUX_W-1:0]          r_mux_therm;
    logic [RAW_W-1:0]          r_floor;
    logic [RAW_W-1:0]          r_ceil;
    logic                      r_out_valid;
    logic [MUX_W-1:0]          r_out_mux;
    logic                      r_out_delayed;
    logic                      r_out_done;
    logic [RAW_W-1:0]          r_out_moist;
    logic [PERMILLE_W-1:0]     r_out_permille;
    logic [SAMPLE_W-1:0]       r_out_therm;

    logic                      accept;
    logic                      out_free;
    logic                      out_load;
    logic [SLOT_W-1:0]         cur_slot;
    logic                      last_slot;
    logic [SLOT_W-1:0]         nxt_slot;
    logic [SLOT_W-1:0]         mux_slot;
    logic [MUX_W-1:0]          mux_sel;
    t_uword                    uword;
    logic                      cond_true;
    logic [UPC_W-1:0]          upc_next;
    logic signed [ACC_W-1:0]   store_ext;
    logic signed [ACC_W-1:0]   acc_next;
    logic [ACC_W-1:0]          acc_abs;
    logic [AVGP_W-1:0]         avg_prod;
    logic [DVS_W:0]            rem_sh;
    logic [DVS_W:0]            rem_sub;
    logic                      rem_ge;
    logic [DVS_W-1:0]          rem_new;
    logic signed [MOIST_W-1:0] quo_s;
    logic signed [MOIST_W-1:0] q_s;
    logic signed [MOIST_W-1:0] m_s;
    logic [RAW_W-1:0]          moist_clamped;
    logic                      below_floor;
    logic                      saturated;
    logic [RAW_W-1:0]          diff_m;
    logic [PROD_W-1:0]         prod;
    logic [PERMILLE_W-1:0]     sat_value;

    assign accept      = i_valid && !o_stall;
    assign out_free    = !r_out_valid || !i_stall;
    assign o_stall     = (r_state != S_IDLE) || !out_free;
    assign o_cfg_ready = 1'b1;

    assign cur_slot  = (r_slot >= SLOT_W'(SLOTS)) ? '0 : r_slot;
    assign last_slot = (cur_slot == SLOT_W'(SLOTS - 1));
    assign nxt_slot  = last_slot ? '0 : cur_slot + 1'b1;
    assign mux_slot  = (r_state == S_IDLE) ? nxt_slot : r_slot;

    always_comb begin
        if (mux_slot == SLOT_W'(SLOTS - 1)) begin
            mux_sel = r_mux_therm;
        end else if (mux_slot[0]) begin
            mux_sel = r_mux_high;
        end else begin
            mux_sel = r_mux_low;
        end
    end

    assign uword = uc_rom(r_upc);

    assign out_load = (r_state == S_IDLE) ? (accept && !last_slot)
                                          : (uword.op == UOP_FINISH && out_free);

    // Odd slots hold high readings, even slots low readings.
    assign store_ext = signed'(ACC_W'(r_store[r_idx]));
    assign acc_next  = r_idx[0] ? (r_acc + store_ext) : (r_acc - store_ext);
    assign acc_abs   = r_acc[ACC_W-1] ? unsigned'(-r_acc) : unsigned'(r_acc);
    assign avg_prod  = AVGP_W'(acc_abs[MAG_W-1:0]) * AVGP_W'(RECIP);

    assign rem_sh  = {r_rem, r_quo[DVD_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_dvs};
    assign rem_ge  = (rem_sh >= {1'b0, r_dvs});
    assign rem_new = rem_ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];

    assign quo_s = signed'({2'b00, r_quo[MAG_W-1:0]});
    assign q_s   = r_neg ? -quo_s : quo_s;
    assign m_s   = signed'(MOIST_W'(FULL_SCALE)) - q_s;

    always_comb begin
        if (m_s < 0) begin
            moist_clamped = '0;
        end else if (m_s > signed'(MOIST_W'(RAW_MAX))) begin
            moist_clamped = RAW_W'(RAW_MAX);
        end else begin
            moist_clamped = m_s[RAW_W-1:0];
        end
    end

    assign below_floor = (r_moist < r_floor);
    assign saturated   = below_floor || (r_moist > r_ceil) || (r_ceil == r_floor);
    assign sat_value   = below_floor ? '0 : PERMILLE_W'(PERMILLE);
    assign diff_m      = r_moist - r_floor;
    assign prod        = PROD_W'(diff_m) * PROD_W'(PERMILLE);

    always_comb begin
        case (uword.cond)
            COND_IDX_MORE:  cond_true = (r_idx != SLOT_W'(SLOTS - 2));
            COND_DIV_MORE:  cond_true = (r_cnt != DCNT_W'(DVD_W - 1));
            COND_SATURATED: cond_true = saturated;
            COND_OUT_BUSY:  cond_true = !out_free;
            default:        cond_true = 1'b0;
        endcase
    end

    assign upc_next = cond_true ? uword.target : r_upc + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_upc       <= UPC_CLEAR;
            r_slot      <= '0;
            r_moist     <= '0;
            r_permille  <= '0;
            r_out_valid <= 1'b0;
            r_mux_low   <= MUX_LOW_RESET;
            r_mux_high  <= MUX_HIGH_RESET;
            r_mux_therm <= MUX_THERM_RESET;
            r_floor     <= FLOOR_RESET;
            r_ceil      <= CEILING_RESET;
            for (int k = 0; k < SLOTS; k++) begin
                r_store[k] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_MUX_LOW:   r_mux_low   <= i_cfg_data[MUX_W-1:0];
                    CFG_MUX_HIGH:  r_mux_high  <= i_cfg_data[MUX_W-1:0];
                    CFG_MUX_THERM: r_mux_therm <= i_cfg_data[MUX_W-1:0];
                    CFG_FLOOR:     r_floor     <= i_cfg_data[RAW_W-1:0];
                    CFG_CEILING:   r_ceil      <= i_cfg_data[RAW_W-1:0];
                    default: ;
                endcase
            end

            if (r_out_valid && !i_stall && !out_load) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_store[cur_slot] <= i_sample;
                        r_slot            <= nxt_slot;
                        if (last_slot) begin
                            r_state <= S_RUN;
                            r_upc   <= UPC_CLEAR;
                        end else begin
                            r_out_valid    <= 1'b1;
                            r_out_mux      <= mux_sel;
                            r_out_delayed  <= !nxt_slot[0];
                            r_out_done     <= 1'b0;
                            r_out_moist    <= r_moist;
                            r_out_permille <= r_permille;
                            r_out_therm    <= r_store[SLOTS-1];
                        end
                    end
                end
                S_RUN: begin
                    r_upc <= upc_next;
                    unique case (uword.op)
                        UOP_CLEAR: begin
                            r_acc <= '0;
                            r_idx <= '0;
                        end
                        UOP_ACCUM: begin
                            r_acc <= acc_next;
                            r_idx <= r_idx + 1'b1;
                        end
                        UOP_LOAD_AVG: begin
                            r_quo <= DVD_W'(avg_prod[AVGP_W-1:RECIP_SHIFT]);
                            r_neg <= r_acc[ACC_W-1];
                        end
                        UOP_DIV_STEP: begin
                            r_quo <= {r_quo[DVD_W-2:0], rem_ge};
                            r_rem <= rem_new;
                            r_cnt <= r_cnt + 1'b1;
                        end
                        UOP_MOIST: begin
                            r_moist <= moist_clamped;
                        end
                        UOP_RANGE: begin
                            if (saturated) begin
                                r_permille <= sat_value;
                            end else begin
                                r_quo <= DVD_W'(prod);
                                r_dvs <= r_ceil - r_floor;
                                r_rem <= '0;
                                r_cnt <= '0;
                            end
                        end
                        UOP_PERMILLE: begin
                            r_permille <= r_quo[PERMILLE_W-1:0];
                        end
                        UOP_FINISH: begin
                            if (out_free) begin
                                r_state        <= S_IDLE;
                                r_out_valid    <= 1'b1;
                                r_out_mux      <= mux_sel;
                                r_out_delayed  <= !r_slot[0];
                                r_out_done     <= 1'b1;
                                r_out_moist    <= r_moist;
                                r_out_permille <= r_permille;
                                r_out_therm    <= r_store[SLOTS-1];
                            end
                        end
                        default: ;
                    endcase
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid             = r_out_valid;
    assign o_next_mux          = r_out_mux;
    assign o_start_delayed     = r_out_delayed;
    assign o_cycle_done        = r_out_done;
    assign o_moisture_raw      = r_out_moist;
    assign o_moisture_permille = r_out_permille;
    assign o_thermistor_raw    = r_out_therm;

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot < SLOT_W'(SLOTS))
        else $error("slot index left the ring");

    a_last_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && last_slot) |=> (r_state == S_RUN && r_slot == '0))
        else $error("completed cycle did not start the sequencer");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && r_upc != UPC_FINISH && !r_out_valid) |=> !r_out_valid)
        else $error("result issued before the sequencer finished");

    a_permille_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_permille <= PERMILLE_W'(PERMILLE))
        else $error("per-mille value above full scale");

    a_moist_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |=> $stable(r_moist))
        else $error("moisture value changed while idle");

endmodule
